// File: hw/rtl/ffu_pkg.sv
package ffu_pkg;

	// sizes
	localparam int KEY_BYTES  = 8;
	localparam int KEY_IDX_W  = $clog2(KEY_BYTES);
	localparam int MAX_VALUE  = 128;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	// character codes
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_TEXT = 2'd0;
	localparam logic [1:0] REG_KEY_LEN  = 2'd1;
	localparam logic [1:0] REG_CAPACITY = 2'd2;

	// reset values of the configuration registers
	localparam logic [63:0] KEY_TEXT_RST = 64'd0;
	localparam logic [3:0]  KEY_LEN_RST  = 4'd1;
	localparam logic [7:0]  CAPACITY_RST = 8'd33;

	// final status codes
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_FOUND  = 2'd1,
		ST_TOO_LONG   = 2'd2,
		ST_BAD_ESCAPE = 2'd3
	} status_t;

	// scan phase, one-hot
	typedef enum logic [3:0] {
		PH_KEY   = 4'b0001,
		PH_SKIP  = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	// escape decoder phase, one-hot
	typedef enum logic [2:0] {
		ESC_NONE = 3'b001,
		ESC_HI   = 3'b010,
		ESC_LO   = 3'b100
	} esc_t;

	// one queued job for the back end: optional data byte, optional status
	typedef struct packed {
		logic       has_data;
		logic [7:0] data;
		logic       has_status;
		status_t    status;
	} job_t;

	// hex digit value in the low nibble, bit 4 set when not a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b0, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/form_field_extract_url_decode_unit.sv
// path: a result is written into the job queue when its input byte is accepted, then
//   loaded into the output register, from which it leaves once m_tready is high
// throughput: one body byte per cycle while m_tready stays high and the job queue is not full;
//   a final byte that also yields data sends data then status, the four-entry job queue absorbs that
// reset: arst_n clears scan state, queue and output valid at once; registers take
//   key_text 0, key_length 1, output_capacity 33
module form_field_extract_url_decode_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] body_byte
	input  logic        s_tlast,   // end_of_body
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] data_byte, [9:8] status, zero above
	output logic        m_tuser,   // is_status
	output logic        m_tlast,   // last_result
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	ffu_pkg::job_t push_job, head;
	logic          push, pop, empty, full;

	// byte classification and scan state
	ffu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_full    (full),
		.q_push    (push),
		.q_job     (push_job)
	);

	// job queue between front and back
	ffu_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	// result output
	ffu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// File: hw/rtl/ffu_front.sv
module ffu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] body_byte
	input  logic               s_tlast,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_wdata,
	input  logic               q_full,
	output logic               q_push,
	output ffu_pkg::job_t      q_job
);

	logic [63:0]     key_text_q;
	logic [3:0]      key_len_q;
	logic [7:0]      capacity_q;

	ffu_pkg::phase_t ph_q, ph_d;
	logic [3:0]      kmi_q, kmi_d;
	logic [7:0]      cnt_q, cnt_d;
	ffu_pkg::esc_t   esc_q, esc_d;
	logic [3:0]      hi_q, hi_d;
	logic            err_q, err_d;
	logic            found_q, found_d;

	logic            accept;
	logic [3:0]      klen;
	logic [7:0]      limit;
	logic [7:0]      key_byte;
	logic [4:0]      hex;
	logic            emit_data;
	logic [7:0]      data_val;
	ffu_pkg::status_t st;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_text_q <= ffu_pkg::KEY_TEXT_RST;
			key_len_q  <= ffu_pkg::KEY_LEN_RST;
			capacity_q <= ffu_pkg::CAPACITY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ffu_pkg::REG_KEY_TEXT: key_text_q <= cfg_wdata;
				ffu_pkg::REG_KEY_LEN:  key_len_q  <= cfg_wdata[3:0];
				ffu_pkg::REG_CAPACITY: capacity_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// effective key length and value limit
	assign klen  = (key_len_q > 4'(ffu_pkg::KEY_BYTES)) ? 4'(ffu_pkg::KEY_BYTES) : key_len_q;
	assign limit = (capacity_q < 8'(ffu_pkg::MAX_VALUE)) ? capacity_q : 8'(ffu_pkg::MAX_VALUE);
	assign key_byte = key_text_q[kmi_q[ffu_pkg::KEY_IDX_W-1:0]*8 +: 8];
	assign hex = ffu_pkg::hex_digit(s_tdata);

	// classify the byte and work out the next scan state
	always_comb begin
		ph_d      = ph_q;
		kmi_d     = kmi_q;
		cnt_d     = cnt_q;
		esc_d     = esc_q;
		hi_d      = hi_q;
		err_d     = err_q;
		found_d   = found_q;
		emit_data = 1'b0;
		data_val  = s_tdata;
		unique case (ph_q)
			ffu_pkg::PH_KEY: begin
				if (s_tdata == ffu_pkg::CH_AMP) begin
					kmi_d = 4'd0;
				end else if (kmi_q < klen) begin
					if (s_tdata == key_byte) kmi_d = kmi_q + 4'd1;
					else ph_d = ffu_pkg::PH_SKIP;
				end else if (s_tdata == ffu_pkg::CH_EQ) begin
					ph_d    = ffu_pkg::PH_VALUE;
					found_d = 1'b1;
				end else begin
					ph_d = ffu_pkg::PH_SKIP;
				end
			end
			ffu_pkg::PH_SKIP: begin
				if (s_tdata == ffu_pkg::CH_AMP) begin
					ph_d  = ffu_pkg::PH_KEY;
					kmi_d = 4'd0;
				end
			end
			ffu_pkg::PH_VALUE: begin
				if (s_tdata == ffu_pkg::CH_AMP) begin
					if (esc_q != ffu_pkg::ESC_NONE) err_d = 1'b1;
					esc_d = ffu_pkg::ESC_NONE;
					ph_d  = ffu_pkg::PH_DONE;
				end else begin
					if (cnt_q != 8'hFF) cnt_d = cnt_q + 8'd1;
					if (!err_q) begin
						unique case (esc_q)
							ffu_pkg::ESC_NONE: begin
								if (s_tdata == ffu_pkg::CH_PCT) begin
									esc_d = ffu_pkg::ESC_HI;
								end else begin
									emit_data = 1'b1;
									data_val  = (s_tdata == ffu_pkg::CH_PLUS) ?
										ffu_pkg::CH_SPACE : s_tdata;
								end
							end
							ffu_pkg::ESC_HI: begin
								if (hex[4]) begin
									err_d = 1'b1;
									esc_d = ffu_pkg::ESC_NONE;
								end else begin
									hi_d  = hex[3:0];
									esc_d = ffu_pkg::ESC_LO;
								end
							end
							ffu_pkg::ESC_LO: begin
								esc_d = ffu_pkg::ESC_NONE;
								if (hex[4]) begin
									err_d = 1'b1;
								end else begin
									emit_data = 1'b1;
									data_val  = {hi_q, hex[3:0]};
								end
							end
							default: ;
						endcase
					end
				end
			end
			ffu_pkg::PH_DONE: ;
			default: ;
		endcase
	end

	// final status from the updated state
	always_comb begin
		priority if (!found_d) st = ffu_pkg::ST_NOT_FOUND;
		else if (cnt_d >= limit) st = ffu_pkg::ST_TOO_LONG;
		else if (err_d || esc_d != ffu_pkg::ESC_NONE) st = ffu_pkg::ST_BAD_ESCAPE;
		else st = ffu_pkg::ST_OK;
	end

	// job for the back end
	assign q_push            = accept && (emit_data || s_tlast);
	assign q_job.has_data    = emit_data;
	assign q_job.data        = data_val;
	assign q_job.has_status  = s_tlast;
	assign q_job.status      = st;

	// scan state, cleared at the body end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= ffu_pkg::PH_KEY;
			kmi_q   <= 4'd0;
			cnt_q   <= 8'd0;
			esc_q   <= ffu_pkg::ESC_NONE;
			hi_q    <= 4'd0;
			err_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				ph_q    <= ffu_pkg::PH_KEY;
				kmi_q   <= 4'd0;
				cnt_q   <= 8'd0;
				esc_q   <= ffu_pkg::ESC_NONE;
				hi_q    <= 4'd0;
				err_q   <= 1'b0;
				found_q <= 1'b0;
			end else begin
				ph_q    <= ph_d;
				kmi_q   <= kmi_d;
				cnt_q   <= cnt_d;
				esc_q   <= esc_d;
				hi_q    <= hi_d;
				err_q   <= err_d;
				found_q <= found_d;
			end
		end
	end

endmodule

// File: hw/rtl/ffu_fifo.sv
module ffu_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ffu_pkg::job_t push_job,
	input  logic          pop,
	output ffu_pkg::job_t head,
	output logic          empty,
	output logic          full
);

	ffu_pkg::job_t                 mem_q [ffu_pkg::FIFO_DEPTH];
	logic [ffu_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [ffu_pkg::FIFO_PTR_W:0]   count_q;
	logic                           do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == (ffu_pkg::FIFO_PTR_W+1)'(ffu_pkg::FIFO_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + (ffu_pkg::FIFO_PTR_W)'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + (ffu_pkg::FIFO_PTR_W)'(1);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (ffu_pkg::FIFO_PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (ffu_pkg::FIFO_PTR_W+1)'(1);
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/ffu_back.sv
module ffu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ffu_pkg::job_t head,
	input  logic          empty,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [15:0]   m_tdata,   // [7:0] data_byte, [9:8] status, zero above
	output logic          m_tuser,   // is_status
	output logic          m_tlast
);

	logic             out_valid_q;
	logic [7:0]       out_data_q;
	ffu_pkg::status_t out_status_q;
	logic             out_is_status_q;
	logic             data_done_q;
	logic             load;
	logic             send_data;

	// output register free or draining this cycle
	assign load      = (!out_valid_q || m_tready) && !empty;
	assign send_data = head.has_data && !data_done_q;
	assign pop       = load && (!send_data || !head.has_status);

	// split a job into its data and status transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			data_done_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (load) data_done_q <= send_data && head.has_status;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (send_data) begin
				out_data_q      <= head.data;
				out_status_q    <= ffu_pkg::ST_OK;
				out_is_status_q <= 1'b0;
			end else begin
				out_data_q      <= 8'd0;
				out_status_q    <= head.status;
				out_is_status_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_status_q, out_data_q};
	assign m_tuser  = out_is_status_q;
	assign m_tlast  = out_is_status_q;

endmodule

// File: dv/form_field_extract_url_decode_unit_test.sv
`timescale 1ns / 100ps

module form_field_extract_url_decode_unit_test;

	// one output transaction, unpacked from the master side
	typedef struct packed {
		logic [7:0]       data;
		logic             is_status;
		ffu_pkg::status_t status;
		logic             last;
	} field_result_t;

	// one register setting for a phase of the run
	typedef struct packed {
		logic [63:0] key;
		logic [3:0]  len;
		logic [7:0]  cap;
	} form_setting_t;

	// tracks the form scan and holds the decoded bytes and statuses still due
	class form_field_scoreboard;
		logic [63:0]     key_text;
		logic [3:0]      key_len;
		logic [7:0]      capacity;
		ffu_pkg::phase_t phase;
		int              matched;
		int              value_len;
		ffu_pkg::esc_t   esc;
		logic [3:0]      hi_nibble;
		bit              bad_escape;
		bit              found;
		field_result_t   expected_q[$];
		int              errors;
		int              data_seen;
		int              status_seen[4];

		function new();
			key_text = ffu_pkg::KEY_TEXT_RST;
			key_len = ffu_pkg::KEY_LEN_RST;
			capacity = ffu_pkg::CAPACITY_RST;
			errors = 0;
			data_seen = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			restart();
		endfunction

		function void restart();
			phase = ffu_pkg::PH_KEY;
			matched = 0;
			value_len = 0;
			esc = ffu_pkg::ESC_NONE;
			hi_nibble = 4'd0;
			bad_escape = 1'b0;
			found = 1'b0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] v);
			case (idx)
				ffu_pkg::REG_KEY_TEXT: key_text = v;
				ffu_pkg::REG_KEY_LEN: key_len = v[3:0];
				ffu_pkg::REG_CAPACITY: capacity = v[7:0];
				default: ;
			endcase
		endfunction

		// low nibble holds the digit value, bit 4 flags a non-hex byte
		function logic [4:0] nibble_of(logic [7:0] c);
			if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
			if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b0, c[3:0] + 4'd9};
			return 5'b10000;
		endfunction

		function void push(logic [7:0] d, logic st_flag, ffu_pkg::status_t st);
			field_result_t r;
			r.data = d;
			r.is_status = st_flag;
			r.status = st;
			r.last = st_flag;
			expected_q.push_back(r);
		endfunction

		// advance the scan by one accepted body byte
		function void note_byte(logic [7:0] b, logic eob);
			int               klen;
			int               limit;
			logic [4:0]       d;
			ffu_pkg::status_t st;
			klen = (key_len > ffu_pkg::KEY_BYTES) ? ffu_pkg::KEY_BYTES : key_len;
			case (phase)
				ffu_pkg::PH_KEY: begin
					if (b == ffu_pkg::CH_AMP) begin
						matched = 0;
					end else if (matched < klen) begin
						if (b == key_text[8 * matched +: 8]) matched++;
						else phase = ffu_pkg::PH_SKIP;
					end else if (b == ffu_pkg::CH_EQ) begin
						phase = ffu_pkg::PH_VALUE;
						found = 1'b1;
					end else begin
						phase = ffu_pkg::PH_SKIP;
					end
				end
				ffu_pkg::PH_SKIP: begin
					if (b == ffu_pkg::CH_AMP) begin
						phase = ffu_pkg::PH_KEY;
						matched = 0;
					end
				end
				ffu_pkg::PH_VALUE: begin
					if (b == ffu_pkg::CH_AMP) begin
						if (esc != ffu_pkg::ESC_NONE) bad_escape = 1'b1;
						esc = ffu_pkg::ESC_NONE;
						phase = ffu_pkg::PH_DONE;
					end else begin
						if (value_len < 255) value_len++;
						// decoding stops for good at the first bad escape
						if (!bad_escape) begin
							if (esc == ffu_pkg::ESC_NONE) begin
								if (b == ffu_pkg::CH_PCT) esc = ffu_pkg::ESC_HI;
								else push((b == ffu_pkg::CH_PLUS) ? ffu_pkg::CH_SPACE : b,
									1'b0, ffu_pkg::ST_OK);
							end else begin
								d = nibble_of(b);
								if (d[4]) begin
									bad_escape = 1'b1;
									esc = ffu_pkg::ESC_NONE;
								end else if (esc == ffu_pkg::ESC_HI) begin
									hi_nibble = d[3:0];
									esc = ffu_pkg::ESC_LO;
								end else begin
									push({hi_nibble, d[3:0]}, 1'b0, ffu_pkg::ST_OK);
									esc = ffu_pkg::ESC_NONE;
								end
							end
						end
					end
				end
				default: ;
			endcase
			// status at the body end, too_long ahead of bad_escape
			if (eob) begin
				limit = (capacity < ffu_pkg::MAX_VALUE) ? capacity : ffu_pkg::MAX_VALUE;
				if (!found) st = ffu_pkg::ST_NOT_FOUND;
				else if (value_len >= limit) st = ffu_pkg::ST_TOO_LONG;
				else if (bad_escape || esc != ffu_pkg::ESC_NONE) st = ffu_pkg::ST_BAD_ESCAPE;
				else st = ffu_pkg::ST_OK;
				push(8'd0, 1'b1, st);
				restart();
			end
		endfunction

		function void report(string what, int want_v, int got_v);
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
		endfunction

		function void check_result(field_result_t got);
			field_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, actual data %0h flag %b status %0d last %b",
					$time, got.data, got.is_status, got.status, got.last);
				return;
			end
			want = expected_q.pop_front();
			if (got.data !== want.data) report("data_byte", want.data, got.data);
			if (got.is_status !== want.is_status) report("is_status", want.is_status, got.is_status);
			if (got.status !== want.status) report("status", want.status, got.status);
			if (got.last !== want.last) report("last_result", want.last, got.last);
			if (want.is_status) status_seen[int'(want.status)]++;
			else data_seen++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [7:0] body_byte
	logic        s_tlast = 1'b0;   // end_of_body
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // [7:0] data_byte, [9:8] status
	logic        m_tuser;          // is_status
	logic        m_tlast;          // last_result
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = ffu_pkg::REG_KEY_TEXT;
	logic [63:0] cfg_wdata = 64'd0;

	form_field_scoreboard form_sb;

	// body generator view of the current key
	logic [7:0] key_chars[8];
	int         key_used = 0;
	int         value_limit = 1;
	logic [7:0] body_q[$];

	int burst_left = 0;
	int bytes_sent = 0;
	int bodies_sent = 0;
	int results_seen = 0;

	// receiver stall state
	int hold_left = 0;
	bit hold_done = 1'b0;
	int window_left = 0;
	int stall_mode = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	form_field_extract_url_decode_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// sender: bursts of random length separated by random gaps
	task automatic push_byte(input logic [7:0] b, input logic eob);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eob;
		do @(posedge clk); while (s_tready !== 1'b1);
		form_sb.note_byte(b, eob);
		bytes_sent++;
		if (eob) bodies_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
	endtask

	// stop offering, wait for every expected transaction, then let the pipe empty
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (form_sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		form_sb.write_reg(idx, v);
	endtask

	task automatic apply_setting(input form_setting_t cfg);
		write_reg(ffu_pkg::REG_KEY_TEXT, cfg.key);
		write_reg(ffu_pkg::REG_KEY_LEN, {60'd0, cfg.len});
		write_reg(ffu_pkg::REG_CAPACITY, {56'd0, cfg.cap});
		@(negedge clk);
		cfg_we <= 1'b0;
		key_used = (cfg.len > ffu_pkg::KEY_BYTES) ? ffu_pkg::KEY_BYTES : cfg.len;
		for (int i = 0; i < 8; i++) key_chars[i] = cfg.key[8 * i +: 8];
		value_limit = (cfg.cap < ffu_pkg::MAX_VALUE) ? cfg.cap : ffu_pkg::MAX_VALUE;
		if (value_limit < 1) value_limit = 1;
	endtask

	function automatic logic [7:0] plain_char();
		string      alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.*~";
		logic [7:0] c;
		if ($urandom_range(0, 2) != 0) return alnum[$urandom_range(0, alnum.len() - 1)];
		do c = 8'($urandom_range(1, 255)); while (c == ffu_pkg::CH_AMP || c == ffu_pkg::CH_PCT);
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 10) return 8'h30 + v;
		return 8'((($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + v - 10);
	endfunction

	// value text: plain bytes, plus signs, escapes good and bad, sometimes overlong
	task automatic add_value();
		int         n;
		int         r;
		logic [7:0] c;
		logic [4:0] nib;
		if ($urandom_range(0, 11) == 0)
			n = $urandom_range((value_limit > 2) ? value_limit - 2 : 0, value_limit + 3);
		else
			n = $urandom_range(0, 10);
		while (n > 0) begin
			r = $urandom_range(0, 29);
			if (r < 20) begin
				body_q.push_back(plain_char());
				n--;
			end else if (r < 23) begin
				body_q.push_back(ffu_pkg::CH_PLUS);
				n--;
			end else if (r < 28) begin
				body_q.push_back(ffu_pkg::CH_PCT);
				body_q.push_back(hex_char(4'($urandom_range(0, 15))));
				body_q.push_back(hex_char(4'($urandom_range(0, 15))));
				n -= 3;
			end else if (r == 28) begin
				do begin
					c = 8'($urandom_range(1, 255));
					nib = form_sb.nibble_of(c);
				end while (!nib[4]);
				body_q.push_back(ffu_pkg::CH_PCT);
				body_q.push_back(c);
				n -= 2;
			end else begin
				body_q.push_back(ffu_pkg::CH_PCT);
				n--;
			end
		end
		// escape cut short by the end of the value
		if ($urandom_range(0, 19) == 0) begin
			body_q.push_back(ffu_pkg::CH_PCT);
			if ($urandom_range(0, 1) != 0) body_q.push_back(hex_char(4'($urandom_range(0, 15))));
		end
	endtask

	// mostly well-formed forms around the key, some pure noise
	task automatic build_body();
		int         nf;
		int         k;
		int         m;
		int         r;
		logic [7:0] c;
		body_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			m = $urandom_range(1, 12);
			repeat (m) begin
				r = $urandom_range(0, 5);
				if (r == 0) body_q.push_back(ffu_pkg::CH_AMP);
				else if (r == 1) body_q.push_back(ffu_pkg::CH_EQ);
				else if (r == 2) body_q.push_back(ffu_pkg::CH_PCT);
				else body_q.push_back(8'($urandom_range(1, 255)));
			end
		end else begin
			nf = $urandom_range(1, 4);
			for (int f = 0; f < nf; f++) begin
				if (f > 0 || $urandom_range(0, 15) == 0) body_q.push_back(ffu_pkg::CH_AMP);
				k = $urandom_range(0, 9);
				if (k <= 4 || k == 6) begin
					for (int i = 0; i < key_used; i++) body_q.push_back(key_chars[i]);
					if (k == 6) body_q.push_back(plain_char());
				end else if (k == 5) begin
					m = (key_used > 0) ? $urandom_range(0, key_used - 1) : 0;
					for (int i = 0; i < m; i++) body_q.push_back(key_chars[i]);
				end else if (k == 7) begin
					m = (key_used > 0) ? $urandom_range(0, key_used - 1) : -1;
					for (int i = 0; i < key_used; i++) begin
						c = key_chars[i];
						if (i == m) c = c ^ (8'h01 << $urandom_range(0, 7));
						body_q.push_back(c);
					end
				end else begin
					m = $urandom_range(0, 5);
					repeat (m) body_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
				end
				if ($urandom_range(0, 9) != 0) begin
					body_q.push_back(ffu_pkg::CH_EQ);
					add_value();
				end
			end
			if ($urandom_range(0, 15) == 0) body_q.push_back(ffu_pkg::CH_AMP);
		end
		if (body_q.size() == 0) body_q.push_back(plain_char());
	endtask

	task automatic send_body();
		build_body();
		foreach (body_q[i]) push_byte(body_q[i], i == body_q.size() - 1);
	endtask

	// receiver ready: changing stall patterns and one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && results_seen >= 200) begin
			hold_done = 1'b1;
			hold_left = 100;
			m_tready <= 1'b0;
		end else begin
			if (window_left == 0) begin
				window_left = $urandom_range(16, 64);
				stall_mode = $urandom_range(0, 2);
			end
			window_left--;
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= (window_left % 3 != 0);
			endcase
		end
	end

	// result check on every output transaction
	always @(posedge clk) begin
		field_result_t got;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			got.data = m_tdata[7:0];
			got.is_status = m_tuser;
			got.status = ffu_pkg::status_t'(m_tdata[9:8]);
			got.last = m_tlast;
			form_sb.check_result(got);
			results_seen++;
		end
	end

	// stimulus
	initial begin
		form_setting_t plan[8];
		int            phase_end;
		form_sb = new();
		plan[0] = '{64'h6B, 4'd1, 8'd1};
		plan[1] = '{64'h72657375, 4'd4, 8'd128};
		plan[2] = '{64'h64726F7773736170, 4'd8, 8'd255};
		plan[3] = '{64'h6D616E5F64697373, 4'd12, 8'd20};
		plan[4] = '{64'h3D3D, 4'd0, 8'd0};
		plan[5] = '{64'h622661, 4'd3, 8'd10};
		plan[6] = '{64'hFFFFFFFFFFFFFFFF, 4'd15, 8'd64};
		plan[7].len = 4'($urandom_range(1, 8));
		plan[7].cap = 8'($urandom_range(1, 128));
		plan[7].key = 64'd0;
		for (int i = 0; i < 8; i++) plan[7].key[8 * i +: 8] = 8'(8'h61 + $urandom_range(0, 25));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset registers: a one-byte zero key, then a zero byte in the body
		push_byte(8'h00, 1'b0);
		send_text("=9");
		settle();

		// directed: bad escape, truncated escape, plus and escape reaching capacity,
		// clean escape, a body with no field at all
		apply_setting('{64'h6261, 4'd2, 8'd4});
		send_text("ab=%4g");
		send_text("ab=%");
		send_text("ab=+%fF");
		send_text("ab=%7e");
		push_byte(8'hFF, 1'b1);
		settle();

		// random forms under each register setting
		foreach (plan[p]) begin
			apply_setting(plan[p]);
			phase_end = bytes_sent + 90;
			while (bytes_sent < phase_end) send_body();
			settle();
		end

		$display("covered %0d bodies, %0d body bytes, %0d decoded bytes under 10 key settings",
			bodies_sent, bytes_sent, form_sb.data_seen);
		$display("statuses: ok %0d, not_found %0d, too_long %0d, bad_escape %0d",
			form_sb.status_seen[0], form_sb.status_seen[1], form_sb.status_seen[2],
			form_sb.status_seen[3]);
		if (form_sb.errors == 0 && form_sb.pending() == 0) begin
			$display("form_field_extract_url_decode_unit_test OK");
		end else begin
			$display("form_field_extract_url_decode_unit_test NOT OK");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3000000;
		$display("timeout with %0d transactions outstanding", form_sb.pending());
		$display("form_field_extract_url_decode_unit_test NOT OK");
		$finish;
	end

endmodule
